// ===== hdl/fcsg_pkg.sv =====
// Shared types, command codes, register offsets and small lookup functions
// for the four-channel sound generator. No dependencies.
package fcsg_pkg;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_FRAME  = 2'd1,
		CMD_TIMER  = 2'd2,
		CMD_SAMPLE = 2'd3
	} cmd_t;

	localparam logic [5:0] REG_SWEEP    = 6'h00;
	localparam logic [5:0] REG_SQ1_LEN  = 6'h01;
	localparam logic [5:0] REG_SQ1_ENV  = 6'h02;
	localparam logic [5:0] REG_SQ1_FLO  = 6'h03;
	localparam logic [5:0] REG_SQ1_FHI  = 6'h04;
	localparam logic [5:0] REG_SQ2_LEN  = 6'h06;
	localparam logic [5:0] REG_SQ2_ENV  = 6'h07;
	localparam logic [5:0] REG_SQ2_FLO  = 6'h08;
	localparam logic [5:0] REG_SQ2_FHI  = 6'h09;
	localparam logic [5:0] REG_WV_DAC   = 6'h0A;
	localparam logic [5:0] REG_WV_LEN   = 6'h0B;
	localparam logic [5:0] REG_WV_VOL   = 6'h0C;
	localparam logic [5:0] REG_WV_FLO   = 6'h0D;
	localparam logic [5:0] REG_WV_FHI   = 6'h0E;
	localparam logic [5:0] REG_NZ_LEN   = 6'h10;
	localparam logic [5:0] REG_NZ_ENV   = 6'h11;
	localparam logic [5:0] REG_NZ_POLY  = 6'h12;
	localparam logic [5:0] REG_NZ_TRIG  = 6'h13;
	localparam logic [5:0] REG_MASTER   = 6'h14;
	localparam logic [5:0] REG_PAN      = 6'h15;
	localparam logic [5:0] REG_POWER    = 6'h16;

	localparam logic [11:0] FREQ_SPAN   = 12'd2048;
	localparam logic [14:0] LFSR_SEED   = 15'h7FFF;
	localparam logic [5:0]  MVOL_RESET  = 6'h3F;

	// bit {duty, pos}
	localparam logic [31:0] DUTY_TABLE = 32'h7EE18180;

	typedef struct packed {
		cmd_t       cmd;
		logic [5:0] reg_index;
		logic [7:0] write_value;
		logic       noise_clock;
	} item_t;

	typedef struct packed {
		logic [8:0] left_mix;
		logic [8:0] right_mix;
		logic [3:0] channel_active;
	} result_t;

	function automatic logic [4:0] noise_divisor(input logic [2:0] code);
		logic [4:0] d;
		unique case (code)
			3'd0:    d = 5'd2;
			3'd1:    d = 5'd4;
			3'd2:    d = 5'd8;
			3'd3:    d = 5'd12;
			3'd4:    d = 5'd16;
			3'd5:    d = 5'd20;
			3'd6:    d = 5'd24;
			default: d = 5'd28;
		endcase
		return d;
	endfunction

endpackage

// ===== hdl/fcsg_item_queue.sv =====
// Two-entry input queue holding accepted items ahead of the execution core.
// Depends on fcsg_pkg.
module fcsg_item_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  fcsg_pkg::item_t din,
	output logic           full,
	input  logic           pop,
	output fcsg_pkg::item_t dout,
	output logic           empty
);
	import fcsg_pkg::*;

	item_t      mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/fcsg_result_queue.sv =====
// Two-entry result queue between the execution core and the result port.
// Depends on fcsg_pkg.
module fcsg_result_queue (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  fcsg_pkg::result_t din,
	output logic             full,
	input  logic             pop,
	output fcsg_pkg::result_t dout,
	output logic             empty
);
	import fcsg_pkg::*;

	result_t    mem_q [2];
	logic [1:0] cnt_q;
	logic       wr_q, rd_q;
	logic       do_push, do_pop;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign dout    = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_q] <= din;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
		end else begin
			if (do_push) wr_q <= !wr_q;
			if (do_pop)  rd_q <= !rd_q;
			unique case ({do_push, do_pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

// ===== hdl/fcsg_core.sv =====
// Execution core: all channel state, one item applied per cycle unless res_full.
// Depends on fcsg_pkg.
module fcsg_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	input  fcsg_pkg::item_t  item,
	output logic             item_take,
	input  logic             res_full,
	output logic             res_push,
	output fcsg_pkg::result_t res
);
	import fcsg_pkg::*;

	typedef struct packed {
		logic [3:0] vol;
		logic       up;
		logic [2:0] per;
		logic [3:0] lvl;
		logic [3:0] div;
		logic       run;
	} env_t;

	typedef struct packed {
		logic [2:0][7:0]  flo;
		logic [15:0][7:0] wmem;
		logic             power;
		logic [7:0]       pan;
		logic [5:0]       mvol;
		logic [2:0]       step;
		logic [1:0]       sq_on, sq_dac, sq_lenon;
		logic [1:0][6:0]  sq_len;
		logic [1:0][1:0]  sq_duty;
		logic [1:0][2:0]  sq_pos;
		logic [1:0][12:0] sq_cnt, sq_per;
		env_t [2:0]       env;
		logic [2:0]       sw_per;
		logic             sw_neg;
		logic [2:0]       sw_shift;
		logic [3:0]       sw_div;
		logic             sw_act;
		logic [10:0]      sw_shadow;
		logic             wv_on, wv_dac, wv_lenon;
		logic [8:0]       wv_len;
		logic [1:0]       wv_vol;
		logic [4:0]       wv_pos;
		logic [11:0]      wv_cnt, wv_per;
		logic             nz_on, nz_dac, nz_lenon;
		logic [6:0]       nz_len;
		logic [3:0]       nz_shift;
		logic             nz_narrow;
		logic [2:0]       nz_code;
		logic [14:0]      lfsr;
		logic [17:0]      nz_cnt;
	} state_t;

	// everything zero except the master volumes
	function automatic state_t reset_state();
		state_t s;
		s      = '0;
		s.mvol = MVOL_RESET;
		return s;
	endfunction

	function automatic env_t env_start(input env_t e);
		env_t r;
		r     = e;
		r.lvl = e.vol;
		r.div = (e.per != 3'd0) ? {1'b0, e.per} : 4'd8;
		r.run = 1'b1;
		return r;
	endfunction

	function automatic env_t env_clock(input env_t e);
		env_t r;
		r = e;
		if (e.run) begin
			if (r.div != 4'd0) r.div = r.div - 4'd1;
			if (r.div == 4'd0) begin
				r.div = (e.per != 3'd0) ? {1'b0, e.per} : 4'd8;
				if (e.up) begin
					if (r.lvl != 4'd15) r.lvl = r.lvl + 4'd1;
				end else begin
					if (r.lvl != 4'd0) r.lvl = r.lvl - 4'd1;
				end
				if (r.lvl == 4'd0 || r.lvl == 4'd15) r.run = 1'b0;
			end
		end
		return r;
	endfunction

	// bit 11 set means the sweep target overflowed
	function automatic logic [11:0] sw_target(input logic [10:0] sh, input logic [2:0] s,
			input logic neg);
		logic [10:0] d;
		d = sh >> s;
		return neg ? ({1'b0, sh} - {1'b0, d}) : ({1'b0, sh} + {1'b0, d});
	endfunction

	function automatic logic [17:0] noise_period(input logic [2:0] code, input logic [3:0] sh);
		return {13'd0, noise_divisor(code)} << sh;
	endfunction

	state_t      st_q, st_d;
	logic        exec;
	logic [5:0]  r;
	logic [7:0]  v;
	logic [3:0]  lvl [4];
	logic [7:0]  wbyte;
	logic [3:0]  wsamp;
	logic [5:0]  lsum, rsum;

	assign exec      = item_valid && !res_full;
	assign item_take = exec;
	assign res_push  = exec && (item.cmd == CMD_SAMPLE);
	assign r         = item.reg_index;
	assign v         = item.write_value;

	always_comb begin
		logic        sel;
		logic [1:0]  k;
		logic [10:0] freq;
		logic [11:0] tgt;
		logic [14:0] l;
		logic        x;
		logic [2:0]  s;
		st_d = st_q;
		sel  = 1'b0;
		k    = 2'd0;
		freq = '0;
		tgt  = '0;
		l    = st_q.lfsr;
		x    = 1'b0;
		s    = st_q.step;
		unique case (item.cmd)
			CMD_WRITE: begin
				if (r[5:4] == 2'b10) begin
					st_d.wmem[r[3:0]] = v;
				end else begin
					unique case (r)
						REG_SWEEP: begin
							st_d.sw_per   = v[6:4];
							st_d.sw_neg   = v[3];
							st_d.sw_shift = v[2:0];
						end
						REG_SQ1_LEN, REG_SQ2_LEN: begin
							sel = (r == REG_SQ2_LEN);
							st_d.sq_duty[sel] = v[7:6];
							st_d.sq_len[sel]  = 7'd64 - {1'b0, v[5:0]};
						end
						REG_SQ1_ENV, REG_SQ2_ENV, REG_NZ_ENV: begin
							k = (r == REG_SQ1_ENV) ? 2'd0 : ((r == REG_SQ2_ENV) ? 2'd1 : 2'd2);
							st_d.env[k].vol = v[7:4];
							st_d.env[k].up  = v[3];
							st_d.env[k].per = v[2:0];
							if (k == 2'd2) begin
								st_d.nz_dac = |v[7:3];
								if (!(|v[7:3])) st_d.nz_on = 1'b0;
							end else begin
								st_d.sq_dac[k[0]] = |v[7:3];
								if (!(|v[7:3])) st_d.sq_on[k[0]] = 1'b0;
							end
						end
						REG_SQ1_FLO: st_d.flo[0] = v;
						REG_SQ2_FLO: st_d.flo[1] = v;
						REG_WV_FLO:  st_d.flo[2] = v;
						REG_SQ1_FHI, REG_SQ2_FHI: begin
							sel  = (r == REG_SQ2_FHI);
							freq = {v[2:0], st_q.flo[sel]};
							st_d.sq_lenon[sel] = v[6];
							st_d.sq_per[sel]   = {FREQ_SPAN - {1'b0, freq}, 1'b0};
							if (v[7]) begin
								st_d.sq_on[sel] = st_q.sq_dac[sel];
								if (st_q.sq_len[sel] == 7'd0) st_d.sq_len[sel] = 7'd64;
								st_d.sq_cnt[sel] = st_d.sq_per[sel];
								st_d.sq_pos[sel] = 3'd0;
								st_d.env[sel] = env_start(st_q.env[sel]);
								if (!sel) begin
									st_d.sw_shadow = freq;
									st_d.sw_div = (st_q.sw_per != 3'd0) ? {1'b0, st_q.sw_per} : 4'd8;
									st_d.sw_act = (st_q.sw_per != 3'd0) || (st_q.sw_shift != 3'd0);
									tgt = sw_target(freq, st_q.sw_shift, st_q.sw_neg);
									if (st_q.sw_shift != 3'd0 && tgt[11]) st_d.sq_on[0] = 1'b0;
								end
							end
						end
						REG_WV_DAC: begin
							st_d.wv_dac = v[7];
							if (!v[7]) st_d.wv_on = 1'b0;
						end
						REG_WV_LEN: st_d.wv_len = 9'd256 - {1'b0, v};
						REG_WV_VOL: st_d.wv_vol = v[6:5];
						REG_WV_FHI: begin
							freq = {v[2:0], st_q.flo[2]};
							st_d.wv_lenon = v[6];
							st_d.wv_per = FREQ_SPAN - {1'b0, freq};
							if (v[7]) begin
								st_d.wv_on = st_q.wv_dac;
								if (st_q.wv_len == 9'd0) st_d.wv_len = 9'd256;
								st_d.wv_cnt = st_d.wv_per;
								st_d.wv_pos = 5'd1;
							end
						end
						REG_NZ_LEN: st_d.nz_len = 7'd64 - {1'b0, v[5:0]};
						REG_NZ_POLY: begin
							st_d.nz_shift  = v[7:4];
							st_d.nz_narrow = v[3];
							st_d.nz_code   = v[2:0];
						end
						REG_NZ_TRIG: begin
							st_d.nz_lenon = v[6];
							if (v[7]) begin
								st_d.nz_on = st_q.nz_dac;
								if (st_q.nz_len == 7'd0) st_d.nz_len = 7'd64;
								st_d.lfsr   = LFSR_SEED;
								st_d.nz_cnt = noise_period(st_q.nz_code, st_q.nz_shift);
								st_d.env[2] = env_start(st_q.env[2]);
							end
						end
						REG_MASTER: st_d.mvol = {v[6:4], v[2:0]};
						REG_PAN:    st_d.pan = v;
						REG_POWER: begin
							st_d.power = v[7];
							if (!v[7]) begin
								st_d.sq_on = 2'b00;
								st_d.wv_on = 1'b0;
								st_d.nz_on = 1'b0;
								st_d.flo   = '0;
							end
						end
						default: ;
					endcase
				end
			end
			CMD_FRAME: begin
				if (!s[0]) begin
					for (int i = 0; i < 2; i++) begin
						if (st_q.sq_lenon[i] && st_q.sq_len[i] != 7'd0) begin
							st_d.sq_len[i] = st_q.sq_len[i] - 7'd1;
							if (st_d.sq_len[i] == 7'd0) st_d.sq_on[i] = 1'b0;
						end
					end
					if (st_q.wv_lenon && st_q.wv_len != 9'd0) begin
						st_d.wv_len = st_q.wv_len - 9'd1;
						if (st_d.wv_len == 9'd0) st_d.wv_on = 1'b0;
					end
					if (st_q.nz_lenon && st_q.nz_len != 7'd0) begin
						st_d.nz_len = st_q.nz_len - 7'd1;
						if (st_d.nz_len == 7'd0) st_d.nz_on = 1'b0;
					end
					// sweep on steps 2 and 6
					if (s[1]) begin
						if (st_d.sw_div != 4'd0) st_d.sw_div = st_d.sw_div - 4'd1;
						if (st_d.sw_div == 4'd0) begin
							st_d.sw_div = (st_q.sw_per != 3'd0) ? {1'b0, st_q.sw_per} : 4'd8;
							if (st_q.sw_act && st_q.sw_per != 3'd0) begin
								tgt = sw_target(st_q.sw_shadow, st_q.sw_shift, st_q.sw_neg);
								if (tgt[11]) begin
									st_d.sq_on[0] = 1'b0;
								end else if (st_q.sw_shift != 3'd0) begin
									st_d.sw_shadow = tgt[10:0];
									st_d.sq_per[0] = {FREQ_SPAN - {1'b0, tgt[10:0]}, 1'b0};
									tgt = sw_target(tgt[10:0], st_q.sw_shift, st_q.sw_neg);
									if (tgt[11]) st_d.sq_on[0] = 1'b0;
								end
							end
						end
					end
				end else if (s == 3'd7) begin
					for (int i = 0; i < 3; i++) st_d.env[i] = env_clock(st_q.env[i]);
				end
				st_d.step = s + 3'd1;
			end
			CMD_TIMER: begin
				for (int i = 0; i < 2; i++) begin
					if (st_q.sq_on[i]) begin
						if (st_q.sq_cnt[i] <= 13'd1) begin
							st_d.sq_cnt[i] = st_q.sq_cnt[i] + st_q.sq_per[i] - 13'd1;
							st_d.sq_pos[i] = st_q.sq_pos[i] + 3'd1;
						end else begin
							st_d.sq_cnt[i] = st_q.sq_cnt[i] - 13'd1;
						end
					end
				end
				if (st_q.wv_on) begin
					if (st_q.wv_cnt <= 12'd1) begin
						st_d.wv_cnt = st_q.wv_cnt + st_q.wv_per - 12'd1;
						st_d.wv_pos = st_q.wv_pos + 5'd1;
					end else begin
						st_d.wv_cnt = st_q.wv_cnt - 12'd1;
					end
				end
				if (item.noise_clock && st_q.nz_on && st_q.nz_shift < 4'd14) begin
					if (st_q.nz_cnt <= 18'd1) begin
						st_d.nz_cnt = st_q.nz_cnt + noise_period(st_q.nz_code, st_q.nz_shift)
							- 18'd1;
						x = l[0] ^ l[1];
						l = {x, l[14:1]};
						if (st_q.nz_narrow) l[6] = x;
						st_d.lfsr = l;
					end else begin
						st_d.nz_cnt = st_q.nz_cnt - 18'd1;
					end
				end
			end
			CMD_SAMPLE: ;
		endcase
	end

	// mixer
	always_comb begin
		for (int i = 0; i < 2; i++) begin
			lvl[i] = (st_q.sq_on[i] && st_q.sq_dac[i] &&
				DUTY_TABLE[{st_q.sq_duty[i], st_q.sq_pos[i]}]) ? st_q.env[i].lvl : 4'd0;
		end
		wbyte = st_q.wmem[st_q.wv_pos[4:1]];
		wsamp = st_q.wv_pos[0] ? wbyte[3:0] : wbyte[7:4];
		lvl[2] = (st_q.wv_on && st_q.wv_dac && st_q.wv_vol != 2'd0)
			? (wsamp >> (st_q.wv_vol - 2'd1)) : 4'd0;
		lvl[3] = (st_q.nz_on && st_q.nz_dac && !st_q.lfsr[0]) ? st_q.env[2].lvl : 4'd0;
		lsum = '0;
		rsum = '0;
		for (int i = 0; i < 4; i++) begin
			if (st_q.pan[4 + i]) lsum = lsum + {2'b00, lvl[i]};
			if (st_q.pan[i])     rsum = rsum + {2'b00, lvl[i]};
		end
		res.left_mix  = st_q.power ? 9'(9'(lsum) * (9'(st_q.mvol[5:3]) + 9'd1)) : 9'd0;
		res.right_mix = st_q.power ? 9'(9'(rsum) * (9'(st_q.mvol[2:0]) + 9'd1)) : 9'd0;
		res.channel_active = {st_q.nz_on, st_q.wv_on, st_q.sq_on};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= reset_state();
		end else if (exec) begin
			st_q <= st_d;
		end
	end

`ifndef SYNTH
	a_power_off: assert property (@(posedge clk) disable iff (!arst_n)
		exec && item.cmd == CMD_WRITE && item.reg_index == REG_POWER && !item.write_value[7]
		|=> st_q.sq_on == 2'b00 && !st_q.wv_on && !st_q.nz_on)
		else $error("channel still on after power off");
	a_on_needs_dac: assert property (@(posedge clk) disable iff (!arst_n)
		(!st_q.sq_on[0] || st_q.sq_dac[0]) && (!st_q.sq_on[1] || st_q.sq_dac[1]) &&
		(!st_q.wv_on || st_q.wv_dac) && (!st_q.nz_on || st_q.nz_dac))
		else $error("channel enabled with its DAC off");
	a_step_only_on_tick: assert property (@(posedge clk) disable iff (!arst_n)
		!(exec && item.cmd == CMD_FRAME) |=> $stable(st_q.step))
		else $error("sequencer step moved without a frame tick");
`endif
endmodule

// ===== hdl/four_channel_sound_generator_unit.sv =====
// Four-voice sound generator: usage notes.
// Items enter through a queue port (push/full); an item is taken at an edge
// with push high and full low. cmd selects register write, frame tick, timer
// clock or sample read. Only a sample read yields a result, which leaves
// through a queue port (empty/pop) with left_mix, right_mix, channel_active.
// Throughput: one item per cycle sustained while the result queue has room,
// limited by the core applying one item per clock to the channel state. A
// sample read waits in the input queue, is applied by the core, which writes
// its result into the result queue, and then shows on the result port for pop.
// Both queues hold two entries. If the result queue fills because pop is
// held low, the core stops taking items, the input queue fills and full
// rises; nothing is dropped. Register writes, ticks and timer clocks keep
// flowing while results are merely waiting, as long as the result queue has
// room. Reset (arst_n low) empties both queues and returns all channel state
// to zero, master volumes to seven, unit powered off.
// Depends on fcsg_pkg, fcsg_item_queue, fcsg_core, fcsg_result_queue.
module four_channel_sound_generator_unit (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [1:0] cmd,
	input  logic [5:0] reg_index,
	input  logic [7:0] write_value,
	input  logic       noise_clock,
	output logic       empty,
	input  logic       pop,
	output logic [8:0] left_mix,
	output logic [8:0] right_mix,
	output logic [3:0] channel_active
);
	import fcsg_pkg::*;

	item_t   in_item, q_item;
	result_t core_res, out_res;
	logic    q_empty, core_take, res_full, res_push;

	always_comb begin
		in_item.cmd         = cmd_t'(cmd);
		in_item.reg_index   = reg_index;
		in_item.write_value = write_value;
		in_item.noise_clock = noise_clock;
	end

	fcsg_item_queue u_in (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.din    (in_item),
		.full   (full),
		.pop    (core_take),
		.dout   (q_item),
		.empty  (q_empty)
	);

	fcsg_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (!q_empty),
		.item       (q_item),
		.item_take  (core_take),
		.res_full   (res_full),
		.res_push   (res_push),
		.res        (core_res)
	);

	fcsg_result_queue u_out (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (res_push),
		.din    (core_res),
		.full   (res_full),
		.pop    (pop),
		.dout   (out_res),
		.empty  (empty)
	);

	assign left_mix       = out_res.left_mix;
	assign right_mix      = out_res.right_mix;
	assign channel_active = out_res.channel_active;
endmodule
